[design/prp_pkg.sv]
// Shared types and register codes for the point rotation block.
// Used by prp_dot and point_rotate_about_pivot; depends on nothing.
`default_nettype none

package prp_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_PIV_X = 3'd3,
    REG_PIV_Y = 3'd4,
    REG_PIV_Z = 3'd5
  } prp_reg_e;

  typedef struct packed {
    logic mul;
    logic comb;
    logic sum;
  } prp_dot_en_t;

endpackage

`default_nettype wire

[design/prp_sub.sv]
// Pivot subtract stage: registers the point minus the pivot on all three axes.
// Standalone; no package needed.
`default_nettype none

module prp_sub #(
  parameter int unsigned COORD_W = 24
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [3*COORD_W-1:0]       pt_i,
  input  logic [3*COORD_W-1:0]       piv_i,
  output logic [3*(COORD_W+1)-1:0]   diff_o
);

  localparam int unsigned DW = COORD_W + 1;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [COORD_W-1:0] pt;
    logic signed [COORD_W-1:0] pv;
    logic signed [DW-1:0]      diff_d;
    logic signed [DW-1:0]      diff_q;

    assign pt     = pt_i[j*COORD_W +: COORD_W];
    assign pv     = piv_i[j*COORD_W +: COORD_W];
    assign diff_d = DW'(pt) - DW'(pv);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        diff_q <= diff_d;
      end
    end

    assign diff_o[j*DW +: DW] = diff_q;
  end

endmodule

`default_nettype wire

[design/prp_dot.sv]
// One matrix row dot product: split partial products, recombine, sum and round.
// Three register stages; imports prp_pkg for the stage enable struct.
`default_nettype none

module prp_dot
  import prp_pkg::*;
#(
  parameter int unsigned COORD_W = 24,
  parameter int unsigned COEF_W  = 16
) (
  input  logic                             clk_i,
  input  prp_dot_en_t                      en_i,
  input  logic [3*COEF_W-1:0]              row_i,
  input  logic [3*(COORD_W+1)-1:0]         diff_i,
  output logic [COEF_W+COORD_W+2:0]        sum_o
);

  localparam int unsigned DW   = COORD_W + 1;
  localparam int unsigned LW   = DW / 2;
  localparam int unsigned HW   = DW - LW;
  localparam int unsigned PLW  = COEF_W + LW + 1;
  localparam int unsigned PHW  = COEF_W + HW;
  localparam int unsigned PW   = COEF_W + DW;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned FRAC = COEF_W - 2;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (FRAC - 1);

  logic signed [PW-1:0] prod [3];
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] sum_q;

  for (genvar j = 0; j < 3; j++) begin : g_col
    logic signed [COEF_W-1:0] coef;
    logic signed [PLW-1:0]    lo_ext;
    logic signed [HW-1:0]     hi;
    logic signed [PLW-1:0]    pl_d;
    logic signed [PLW-1:0]    pl_q;
    logic signed [PHW-1:0]    ph_d;
    logic signed [PHW-1:0]    ph_q;
    logic signed [PW-1:0]     p_d;
    logic signed [PW-1:0]     p_q;

    assign coef   = row_i[j*COEF_W +: COEF_W];
    assign lo_ext = PLW'(diff_i[j*DW +: LW]);
    assign hi     = diff_i[j*DW+LW +: HW];
    assign pl_d   = PLW'(coef) * lo_ext;
    assign ph_d   = PHW'(coef) * PHW'(hi);
    assign p_d    = (PW'(ph_q) <<< LW) + PW'(pl_q);

    always_ff @(posedge clk_i) begin
      if (en_i.mul) begin
        pl_q <= pl_d;
        ph_q <= ph_d;
      end
      if (en_i.comb) begin
        p_q <= p_d;
      end
    end

    assign prod[j] = p_q;
  end

  assign sum_d = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + RND;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

[design/prp_sat.sv]
// Output stage for one axis: drop fraction bits, add the pivot back, saturate.
// Standalone; no package needed.
`default_nettype none

module prp_sat #(
  parameter int unsigned COORD_W = 24,
  parameter int unsigned COEF_W  = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [COEF_W+COORD_W+2:0]  sum_i,
  input  logic [COORD_W-1:0]         piv_i,
  output logic [COORD_W-1:0]         res_o,
  output logic                       ovf_o
);

  localparam int unsigned SW   = COEF_W + COORD_W + 3;
  localparam int unsigned FRAC = COEF_W - 2;
  localparam int unsigned HW   = SW - FRAC;
  localparam int unsigned TW   = HW + 1;
  localparam logic signed [TW-1:0] MAXV = TW'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [TW-1:0] MINV = ~MAXV;

  logic signed [HW-1:0]      sh;
  logic signed [COORD_W-1:0] pv;
  logic signed [TW-1:0]      t;
  logic [COORD_W-1:0]        res_d;
  logic [COORD_W-1:0]        res_q;
  logic                      ovf_d;
  logic                      ovf_q;

  assign sh = sum_i[SW-1:FRAC];
  assign pv = piv_i;
  assign t  = TW'(sh) + TW'(pv);

  always_comb begin
    if (t > MAXV) begin
      res_d = MAXV[COORD_W-1:0];
      ovf_d = 1'b1;
    end else if (t < MINV) begin
      res_d = MINV[COORD_W-1:0];
      ovf_d = 1'b1;
    end else begin
      res_d = t[COORD_W-1:0];
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

[design/point_rotate_about_pivot.sv]
// Top level of the point rotation block: config registers, valid chain, datapath.
// Depends on prp_pkg, prp_sub, prp_dot and prp_sat.
//
// Rotates one signed fixed-point 3D point per cycle about a configured pivot with a
// configured 3x3 matrix. Throughput is one point per clock while the output is not
// stalled. Stages, in order: pivot subtract, split partial products, product
// recombine, row sum with rounding, then pivot add and saturation. Every
// stage holds its own valid bit and empty stages fill while the output is stalled,
// so s_axis_tready falls only when all five stages hold data and m_axis_tready is
// low. Matrix rows and pivot come from the write port; write them only while no
// point is in flight. The overflow bit is set when any coordinate was clamped.
`default_nettype none

module point_rotate_about_pivot
  import prp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // in_x, in_y, in_z from bit 0 up, zero padded to whole bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // out_x, out_y, out_z, overflow from bit 0 up, zero padded to whole bytes
  output logic [((3*COORD_WIDTH+8)/8)*8-1:0]         m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                       cfg_idx_i,
  input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0]
                                                     cfg_data_i
);

  localparam int unsigned ROW_W  = 3 * COEF_WIDTH;
  localparam int unsigned DW     = COORD_WIDTH + 1;
  localparam int unsigned SW     = COEF_WIDTH + COORD_WIDTH + 3;
  localparam int unsigned OUT_W  = ((3*COORD_WIDTH+8)/8)*8;
  localparam int unsigned NSTAGE = 5;
  localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << (COEF_WIDTH - 2);

  logic [ROW_W-1:0]        rows_q [3];
  logic [COORD_WIDTH-1:0]  piv_q  [3];
  logic [NSTAGE-1:0]       v_q;
  logic [NSTAGE-1:0]       v_d;
  logic [NSTAGE:0]         rdy;
  logic [NSTAGE-1:0]       pv;
  logic [NSTAGE-1:0]       ld;
  logic [3*DW-1:0]         diff;
  logic [SW-1:0]           sum [3];
  logic [COORD_WIDTH-1:0]  res [3];
  logic [2:0]              ovf;
  prp_dot_en_t             dot_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rows_q[i] <= ONE << (i * COEF_WIDTH);
        piv_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (prp_reg_e'(cfg_idx_i))
        REG_ROW0:  rows_q[0] <= cfg_data_i[ROW_W-1:0];
        REG_ROW1:  rows_q[1] <= cfg_data_i[ROW_W-1:0];
        REG_ROW2:  rows_q[2] <= cfg_data_i[ROW_W-1:0];
        REG_PIV_X: piv_q[0]  <= cfg_data_i[COORD_WIDTH-1:0];
        REG_PIV_Y: piv_q[1]  <= cfg_data_i[COORD_WIDTH-1:0];
        REG_PIV_Z: piv_q[2]  <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    rdy[NSTAGE] = m_axis_tready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    pv = {v_q[NSTAGE-2:0], s_axis_tvalid};
    ld = rdy[NSTAGE-1:0] & pv;
    for (int k = 0; k < NSTAGE; k++) begin
      v_d[k] = rdy[k] ? pv[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NSTAGE-1];

  assign dot_en.mul  = ld[1];
  assign dot_en.comb = ld[2];
  assign dot_en.sum  = ld[3];

  prp_sub #(
    .COORD_W (COORD_WIDTH)
  ) u_sub (
    .clk_i  (clk_i),
    .en_i   (ld[0]),
    .pt_i   (s_axis_tdata[3*COORD_WIDTH-1:0]),
    .piv_i  ({piv_q[2], piv_q[1], piv_q[0]}),
    .diff_o (diff)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    prp_dot #(
      .COORD_W (COORD_WIDTH),
      .COEF_W  (COEF_WIDTH)
    ) u_dot (
      .clk_i  (clk_i),
      .en_i   (dot_en),
      .row_i  (rows_q[i]),
      .diff_i (diff),
      .sum_o  (sum[i])
    );

    prp_sat #(
      .COORD_W (COORD_WIDTH),
      .COEF_W  (COEF_WIDTH)
    ) u_sat (
      .clk_i (clk_i),
      .en_i  (ld[4]),
      .sum_i (sum[i]),
      .piv_i (piv_q[i]),
      .res_o (res[i]),
      .ovf_o (ovf[i])
    );
  end

  assign m_axis_tdata = OUT_W'({|ovf, res[2], res[1], res[0]});

`ifndef SYNTHESIS
  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) ==
      $countones($past(v_q)) + 32'($past(in_xfer)) - 32'($past(out_xfer)))
    else $error("pipeline occupancy does not match transfers");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q) && !m_axis_tready)
    else $error("input stalled while pipeline has room");

  a_no_bubble_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !v_q[1]) |=> v_q[1])
    else $error("first stage item did not advance into empty stage");
`endif

endmodule

`default_nettype wire

[verif/point_rotate_about_pivot_test.sv]
// Self-checking testbench for point_rotate_about_pivot: directed table, then random phases.
// Depends on prp_pkg and the RTL; predicts untyped points with its own fixed-point model.
`timescale 1ns / 100ps

module point_rotate_about_pivot_test;
  import prp_pkg::*;

  localparam int COORD_W = 24;
  localparam int COEF_W = 16;
  localparam int ROW_W = 3 * COEF_W;
  localparam int IN_W = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W = ((3 * COORD_W + 8) / 8) * 8;
  localparam int FRAC_BITS = COEF_W - 2;
  localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_CYCLES = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t CMAX = 24'sh7FFFFF;
  localparam coord_t CMIN = 24'sh800000;

  localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;
  localparam logic [COEF_W-1:0] COEF_NEG_ONE = 16'hC000;
  localparam logic [COEF_W-1:0] COEF_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;
  localparam logic [ROW_W-1:0] ROW_ID_X = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_ID_Y = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_ID_Z = 48'h4000_0000_0000;

  typedef struct packed {
    logic   ovf;
    coord_t z;
    coord_t y;
    coord_t x;
  } result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     data;
    coord_t               x;
    coord_t               y;
    coord_t               z;
    logic                 typed;
    result_t              want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_ROW0;
  logic [ROW_W-1:0]     cfg_data_i = '0;

  // predictor copy of the register file
  logic [ROW_W-1:0] mat_row [3] = '{ROW_ID_X, ROW_ID_Y, ROW_ID_Z};
  coord_t           pivot [3] = '{24'sd0, 24'sd0, 24'sd0};

  result_t   pending_points [$];
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;
  int        tready_hold = 0;
  int        quiet_cycles = 0;

  point_rotate_about_pivot #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (COEF_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t rotate_point(coord_t px, coord_t py, coord_t pz);
    longint  diff [3];
    longint  acc;
    coord_t  axis_out [3];
    result_t r;
    diff[0] = longint'(px) - longint'(pivot[0]);
    diff[1] = longint'(py) - longint'(pivot[1]);
    diff[2] = longint'(pz) - longint'(pivot[2]);
    r = '0;
    for (int i = 0; i < 3; i++) begin
      acc = ROUND_HALF;
      for (int j = 0; j < 3; j++) begin
        acc += longint'($signed(mat_row[i][j*COEF_W +: COEF_W])) * diff[j];
      end
      acc = (acc >>> FRAC_BITS) + longint'(pivot[i]);
      if (acc > longint'(CMAX)) begin
        acc = CMAX;
        r.ovf = 1'b1;
      end else if (acc < longint'(CMIN)) begin
        acc = CMIN;
        r.ovf = 1'b1;
      end
      axis_out[i] = acc[COORD_W-1:0];
    end
    r.x = axis_out[0];
    r.y = axis_out[1];
    r.z = axis_out[2];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(5))
      0: return COEF_ONE;
      1: return COEF_NEG_ONE;
      2: return COEF_MAX;
      3: return COEF_MIN;
      4: return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_coord(coord_t base);
    case ($urandom_range(9))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3, 4: return base + coord_t'($urandom_range(511)) - coord_t'(256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    directed_rows.push_back(r);
  endtask

  task automatic add_pt(input coord_t px, input coord_t py, input coord_t pz);
    stim_row_t r;
    r = '0;
    r.x = px;
    r.y = py;
    r.z = pz;
    directed_rows.push_back(r);
  endtask

  task automatic add_chk(input coord_t px, input coord_t py, input coord_t pz,
                         input coord_t ex, input coord_t ey, input coord_t ez,
                         input logic eo);
    stim_row_t r;
    r = '0;
    r.x = px;
    r.y = py;
    r.z = pz;
    r.typed = 1'b1;
    r.want.x = ex;
    r.want.y = ey;
    r.want.z = ez;
    r.want.ovf = eo;
    directed_rows.push_back(r);
  endtask

  // hold the write lines until the caller's batch ends
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx <= REG_ROW2) begin
      mat_row[idx] = data;
    end else if (idx <= REG_PIV_Z) begin
      pivot[idx - REG_PIV_X] = data[COORD_W-1:0];
    end
  endtask

  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                            input logic typed, input result_t want);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {pz, py, px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_points.push_back(typed ? want : rotate_point(px, py, pz));
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drain_outputs
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[3*COORD_W:0];
      if (pending_points.size() == 0) begin
        $error("output transfer with no point pending: %h", got);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("overflow", want.ovf, got.ovf);
      end
    end
    if (tready_hold > 0) begin
      m_axis_tready <= 1'b0;
      tready_hold--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic               in_cfg;
    logic [ROW_W-1:0]   rv [3];
    coord_t             pv [3];
    logic [31:0]        junk;
    stim_row_t          r;

    // identity after reset
    add_chk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0);
    add_chk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0);
    add_chk('0, '0, '0, '0, '0, '0, 1'b0);
    add_chk(24'sd1, -24'sd1, 24'sh123456, 24'sd1, -24'sd1, 24'sh123456, 1'b0);
    // negate x, double-negate y: saturate both ways
    add_cfg(REG_ROW0, {32'h0, COEF_NEG_ONE});
    add_chk(CMIN, '0, '0, CMAX, '0, '0, 1'b1);
    add_chk(CMAX, 24'sd5, 24'sd6, -CMAX, 24'sd5, 24'sd6, 1'b0);
    add_cfg(REG_ROW1, {16'h0, COEF_MIN, 16'h0});
    add_chk('0, CMAX, '0, '0, CMIN, '0, 1'b1);
    add_chk('0, CMIN, '0, '0, CMAX, '0, 1'b1);
    add_cfg(REG_ROW2, {COEF_MAX, COEF_MAX, COEF_MAX});
    add_pt(CMAX, CMAX, CMAX);
    add_pt(CMIN, CMIN, CMIN);
    // pivot X and Y writes carry junk above the coordinate width
    add_cfg(REG_PIV_X, 48'hFFFF_FF80_0000);
    add_cfg(REG_PIV_Y, 48'h5A5A_5A7F_FFFF);
    add_cfg(REG_PIV_Z, 48'h0000_0000_0100);
    add_cfg(REG_SPARE_A, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_SPARE_B, 48'h1234_5678_9ABC);
    add_pt(CMAX, CMIN, '0);
    add_pt(CMIN, CMAX, 24'sh000100);
    add_pt('0, '0, '0);
    add_cfg(REG_ROW0, ROW_ID_X);
    add_cfg(REG_ROW1, ROW_ID_Y);
    add_cfg(REG_ROW2, ROW_ID_Z);
    add_chk(CMAX, CMIN, 24'sh000100, CMAX, CMIN, 24'sh000100, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 1'b0;
    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      if (r.is_cfg) begin
        if (!in_cfg) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
          in_cfg = 1'b1;
        end
        cfg_write(r.idx, r.data);
      end else begin
        if (in_cfg) begin
          cfg_we_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_point(r.x, r.y, r.z, r.typed, r.want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          rv = '{ROW_ID_X, ROW_ID_Y, ROW_ID_Z};
          pv = '{24'sd0, 24'sd0, 24'sd0};
        end
        1: begin
          rv = '{3{{COEF_MAX, COEF_MAX, COEF_MAX}}};
          pv = '{CMAX, CMAX, CMAX};
        end
        2: begin
          rv = '{3{{COEF_MIN, COEF_MIN, COEF_MIN}}};
          pv = '{CMIN, CMIN, CMIN};
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            rv[i] = {pick_coef(), pick_coef(), pick_coef()};
            pv[i] = pick_coord('0);
          end
        end
      endcase
      cfg_write(REG_ROW0, rv[0]);
      cfg_write(REG_ROW1, rv[1]);
      cfg_write(REG_ROW2, rv[2]);
      junk = $urandom;
      cfg_write(REG_PIV_X, {junk[23:0], pv[0]});
      junk = $urandom;
      cfg_write(REG_PIV_Y, {junk[23:0], pv[1]});
      junk = $urandom;
      cfg_write(REG_PIV_Z, {junk[23:0], pv[2]});
      if (ph >= 3 && $urandom_range(1) == 1) begin
        cfg_write(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  {$urandom, 16'($urandom)});
      end
      cfg_we_i <= 1'b0;

      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 52; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 52; end
        default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
      endcase
      // back up the pipeline while the sender keeps offering points
      if (ph % 4 == 2) tready_hold = HOLD_CYCLES;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_point(pick_coord(pivot[0]), pick_coord(pivot[1]), pick_coord(pivot[2]),
                   1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
